// File: sv/sli_pkg.sv
// Package for the sorted list block: action and status codes, field widths.
// Used by sli_ctrl and the testbench; no dependencies.
package sli_pkg;
   localparam int ValueWidth = 32;
   localparam int CountWidth = 5;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_LIST   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;
endpackage

// File: sv/sorted_list_insert_delete.sv
// Bounded ascending sorted list of signed 32-bit values held in one RAM with a
// registered read. An insert into a non-empty list scans the entries for its
// place and then moves the entries above it up; a delete scans for a match and
// then moves the entries above it down. A refused insert, a delete or list on an
// empty list and an unused action answer without a scan, and a delete that finds
// nothing answers after scanning every entry. A list gives one entry per cycle
// while the output is not stalled. One item is worked on at a time and the next
// is taken the cycle after its final result transfer; every item yields one
// result, or count results for a list of a non-empty store.
// Depends on sli_ctrl, and through it on sli_pkg and sli_ram.
module sorted_list_insert_delete #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // action[1:0], value[33:2], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[1:0], entry[33:2], count[38:34], zero
   output logic        rsp_tlast
);
   logic [1:0]  st;
   logic [31:0] ent;
   logic [4:0]  cnt;

   sli_ctrl #(.Capacity(CAPACITY)) u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_action(req_tdata[1:0]), .in_value(req_tdata[33:2]),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_status(st), .out_entry(ent), .out_count(cnt), .out_last(rsp_tlast)
   );

   // pack the fields; sli_ctrl already gives a zero entry on non-list results
   assign rsp_tdata = {1'b0, cnt, ent, st};
endmodule

// File: sv/sli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sli_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: sv/sli_ctrl.sv
// Sequencer for the sorted list: scans, shifts and lists entries through one RAM.
// Depends on sli_pkg and sli_ram.
module sli_ctrl #(
   parameter int Capacity = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [1:0]                     in_action,
   input  logic [sli_pkg::ValueWidth-1:0] in_value,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [1:0]                     out_status,
   output logic [sli_pkg::ValueWidth-1:0] out_entry,
   output logic [sli_pkg::CountWidth-1:0] out_count,
   output logic                           out_last
);
   localparam int AW = $clog2(Capacity);
   localparam int NW = $clog2(Capacity + 1);
   localparam int VW = sli_pkg::ValueWidth;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,  // read entry at idx, compare next cycle
      S_SHUP  = 6'b000100,  // insert: move entries up from top to pos
      S_SHDN  = 6'b001000,  // delete: move entries down from pos
      S_LIST  = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [NW-1:0]     count_ff, count_in;
   logic [NW-1:0]     idx_ff, idx_in;      // address issued
   logic              rdv_ff, rdv_in;      // read data valid for idx_ff-1 (scan)
   logic [1:0]        act_ff, act_in;
   logic [VW-1:0]     val_ff, val_in;
   // output register
   logic              ov_ff, ov_in;
   logic [1:0]        ost_ff, ost_in;
   logic [VW-1:0]     oent_ff, oent_in;
   logic              olast_ff, olast_in;
   logic              lent_ff, lent_in;    // list output takes RAM data

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [VW-1:0]     wr_data, rd_data;
   logic [NW-1:0]     prev;

   sli_ram #(.Width(VW), .Depth(Capacity)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   assign prev = idx_ff - NW'(1);
   assign in_ready = (state_ff == S_IDLE) && !ov_ff;
   assign out_valid = ov_ff;
   assign out_status = ost_ff;
   assign out_entry = lent_ff ? rd_data : oent_ff;
   assign out_count = sli_pkg::CountWidth'(count_ff);
   assign out_last = olast_ff;

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; rdv_in = 1'b0;
      act_in = act_ff; val_in = val_ff;
      ov_in = ov_ff; ost_in = ost_ff; oent_in = oent_ff; olast_in = olast_ff;
      lent_in = lent_ff;
      wr_en = 1'b0; wr_addr = AW'(0); wr_data = val_ff;
      rd_addr = AW'(idx_ff);
      if (ov_ff && out_ready) begin
         ov_in = 1'b0; lent_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (in_valid && in_ready) begin
               act_in = in_action; val_in = in_value; idx_in = '0;
               ost_in = sli_pkg::ST_OK; oent_in = '0; olast_in = 1'b1;
               case (sli_pkg::action_type'(in_action))
                  sli_pkg::ACT_INSERT: begin
                     if (count_ff >= NW'(Capacity)) begin
                        ost_in = sli_pkg::ST_FULL; ov_in = 1'b1;
                     end else if (count_ff == '0) begin
                        state_in = S_SHUP;
                     end else begin
                        state_in = S_SCAN; rdv_in = 1'b1;
                        idx_in = NW'(1);
                     end
                  end
                  sli_pkg::ACT_DELETE: begin
                     if (count_ff == '0) begin
                        ost_in = sli_pkg::ST_EMPTY; ov_in = 1'b1;
                     end else begin
                        state_in = S_SCAN; rdv_in = 1'b1; idx_in = NW'(1);
                     end
                  end
                  sli_pkg::ACT_LIST: begin
                     if (count_ff == '0) begin
                        ost_in = sli_pkg::ST_EMPTY; ov_in = 1'b1;
                     end else begin
                        state_in = S_LIST;
                     end
                  end
                  default: ov_in = 1'b1;
               endcase
               rd_addr = AW'(0);
            end
         end
         S_SCAN: begin
            // rd_data holds entry prev; compare it
            rd_addr = AW'(idx_ff);
            rdv_in = 1'b1;
            idx_in = idx_ff + NW'(1);
            if (act_ff == sli_pkg::ACT_INSERT) begin
               if ($signed(val_ff) <= $signed(rd_data)) begin
                  // insert at prev: shift from top down to prev
                  idx_in = prev; state_in = S_SHUP; rdv_in = 1'b0;
               end else if (idx_ff == count_ff) begin
                  idx_in = count_ff; state_in = S_SHUP; rdv_in = 1'b0;
               end
            end else begin
               if (val_ff == rd_data) begin
                  idx_in = prev; state_in = S_SHDN; rdv_in = 1'b0;
               end else if (idx_ff == count_ff) begin
                  ost_in = sli_pkg::ST_NOTFOUND; ov_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
            // idx_ff tracks the position to use; the top pointer lives in oent
            if (state_in == S_SHUP) begin
               // idx_ff now = insertion position; walk from count down
               act_in = act_ff;
            end
         end
         S_SHUP: begin
            // idx_ff = insertion pos; move entries using a top pointer in oent
            // performed as a read of entry k-1 then write at k
            if (!rdv_ff) begin
               // first cycle: set top pointer
               oent_in = VW'(count_ff);
               rd_addr = AW'(count_ff - NW'(1));
               rdv_in = 1'b1;
               if (count_ff == idx_ff) begin
                  wr_en = 1'b1; wr_addr = AW'(idx_ff); wr_data = val_ff;
                  count_in = count_ff + NW'(1); ov_in = 1'b1; state_in = S_IDLE;
                  rdv_in = 1'b0;
               end
            end else begin
               // rd_data = entry[top-1]; write to top
               wr_en = 1'b1; wr_addr = AW'(oent_ff); wr_data = rd_data;
               oent_in = oent_ff - VW'(1);
               rd_addr = AW'(oent_ff - VW'(2));
               rdv_in = 1'b1;
               if (NW'(oent_ff) == idx_ff + NW'(1)) begin
                  rdv_in = 1'b0; state_in = S_OUT;
               end
            end
         end
         S_SHDN: begin
            // move entry k+1 to k for k from pos to count-2
            if (!rdv_ff) begin
               rd_addr = AW'(idx_ff + NW'(1));
               rdv_in = 1'b1;
               if (idx_ff + NW'(1) >= count_ff) begin
                  count_in = count_ff - NW'(1); ov_in = 1'b1;
                  state_in = S_IDLE; rdv_in = 1'b0;
               end
            end else begin
               wr_en = 1'b1; wr_addr = AW'(idx_ff); wr_data = rd_data;
               idx_in = idx_ff + NW'(1);
               rd_addr = AW'(idx_ff + NW'(2));
               if (idx_ff + NW'(2) >= count_ff) begin
                  count_in = count_ff - NW'(1); ov_in = 1'b1;
                  state_in = S_IDLE; rdv_in = 1'b0;
               end else begin
                  rdv_in = 1'b1;
               end
            end
         end
         S_LIST: begin
            // issue a read once the output register is free
            rd_addr = AW'(idx_ff);
            if (!ov_ff || out_ready) begin
               ov_in = 1'b1; lent_in = 1'b1; ost_in = sli_pkg::ST_OK;
               olast_in = (idx_ff + NW'(1) == count_ff);
               // hold the address on the final entry so its read data stays put
               if (idx_ff + NW'(1) == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + NW'(1);
               end
            end else begin
               rd_addr = AW'(prev);
            end
         end
         S_OUT: begin
            // write the new value at its place
            wr_en = 1'b1; wr_addr = AW'(idx_ff); wr_data = val_ff;
            count_in = count_ff + NW'(1); ov_in = 1'b1;
            oent_in = '0; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff != S_SHUP && state_in == S_SHUP) begin
         oent_in = '0;
      end
      if (state_ff == S_SHUP && state_in == S_IDLE) begin
         oent_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; ov_ff <= 1'b0; lent_ff <= 1'b0;
         rdv_ff <= 1'b0; idx_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ov_ff <= ov_in;
         lent_ff <= lent_in; rdv_ff <= rdv_in; idx_ff <= idx_in;
      end
      act_ff <= act_in; val_ff <= val_in; ost_ff <= ost_in;
      oent_ff <= oent_in; olast_ff <= olast_in;
   end
endmodule

// File: tb/sorted_list_insert_delete_tb.sv
// Testbench for sorted_list_insert_delete: drives insert, delete, list and unused transfers with
// random idling and checks every result against a behavioural sorted-list predictor.
// Depends on sli_pkg and the block itself.
`timescale 1ns / 100ps

module sorted_list_insert_delete_tb;

   localparam int Capacity = 16;
   localparam int CycleLimit = 400000;

   typedef struct packed {
      sli_pkg::status_type status;
      logic [31:0]         entry;
      logic [4:0]          count;
      logic                last;
   } result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   logic [33:0] pending_items[$];
   result_type  expected_results[$];
   logic [31:0] model_entries[$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          calm;
   bit          hold_off;

   sorted_list_insert_delete #(.CAPACITY(Capacity)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Append the results that one accepted transfer causes and update the list
   task automatic predict_sorted_list(input logic [33:0] item);
      sli_pkg::action_type act;
      logic [31:0]         val;
      int                  pos;
      result_type          res;
      act = sli_pkg::action_type'(item[1:0]);
      val = item[33:2];
      res = '{sli_pkg::ST_OK, 32'd0, 5'd0, 1'b1};
      case (act)
         sli_pkg::ACT_INSERT: begin
            if (model_entries.size() >= Capacity) begin
               res.status = sli_pkg::ST_FULL;
            end else begin
               pos = model_entries.size();
               for (int i = 0; i < model_entries.size(); i++)
                  if ($signed(val) <= $signed(model_entries[i])) begin
                     pos = i;
                     break;
                  end
               model_entries.insert(pos, val);
            end
         end
         sli_pkg::ACT_DELETE: begin
            if (model_entries.size() == 0) begin
               res.status = sli_pkg::ST_EMPTY;
            end else begin
               pos = -1;
               for (int i = 0; i < model_entries.size(); i++)
                  if (model_entries[i] == val) begin
                     pos = i;
                     break;
                  end
               if (pos < 0) res.status = sli_pkg::ST_NOTFOUND;
               else model_entries.delete(pos);
            end
         end
         sli_pkg::ACT_LIST: begin
            if (model_entries.size() == 0) begin
               res.status = sli_pkg::ST_EMPTY;
            end else begin
               for (int i = 0; i < model_entries.size(); i++) begin
                  res.entry = model_entries[i];
                  res.count = 5'(model_entries.size());
                  res.last = (i == model_entries.size() - 1);
                  expected_results.push_back(res);
               end
               return;
            end
         end
         default: ;
      endcase
      res.count = 5'(model_entries.size());
      expected_results.push_back(res);
   endtask

   function automatic logic [33:0] make_item(sli_pkg::action_type act, logic [31:0] val);
      return {val, act};
   endfunction

   // Draw a value, mostly from a narrow band so deletes and duplicates find matches
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'h7fff_fffc + $urandom_range(0, 3);
         default: return 32'($signed($urandom_range(0, 12)) - 6);
      endcase
   endfunction

   // Driver: offer the next pending item, idling at random
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) predict_sorted_list(req_tdata[33:0]);
         if (!(req_tvalid && !req_tready)) begin
            if ((req_tvalid && req_tready) || !req_tvalid) begin
               if (pending_items.size() > 0 && !hold_off &&
                   (calm || $urandom_range(0, 99) >= 36)) begin
                  req_tvalid <= 1'b1;
                  req_tdata  <= {6'd0, pending_items.pop_front()};
               end else begin
                  req_tvalid <= 1'b0;
               end
            end
         end
      end
   end

   // Monitor: stall at random and compare each result with the oldest expectation
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 36);
         if (rsp_tvalid && rsp_tready) begin
            got = '{sli_pkg::status_type'(rsp_tdata[1:0]), rsp_tdata[33:2],
                    rsp_tdata[38:34], rsp_tlast};
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected st=%0d entry=%h cnt=%0d last=%0b,",
                               " got st=%0d entry=%h cnt=%0d last=%0b"},
                              want.status, want.entry, want.count, want.last,
                              got.status, got.entry, got.count, got.last);
               end
            end
         end
      end
   end

   // Cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      calm = 1'b0;
      hold_off = 1'b0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty cases, extremes, duplicates, full store, unused action
      pending_items.push_back(make_item(sli_pkg::ACT_LIST, 32'd0));
      pending_items.push_back(make_item(sli_pkg::ACT_DELETE, 32'd5));
      pending_items.push_back(make_item(sli_pkg::ACT_NONE, 32'hffff_ffff));
      pending_items.push_back(make_item(sli_pkg::ACT_INSERT, 32'h7fff_ffff));
      pending_items.push_back(make_item(sli_pkg::ACT_INSERT, 32'h8000_0000));
      pending_items.push_back(make_item(sli_pkg::ACT_INSERT, 32'd0));
      pending_items.push_back(make_item(sli_pkg::ACT_INSERT, 32'd0));
      pending_items.push_back(make_item(sli_pkg::ACT_INSERT, 32'hffff_ffff));
      pending_items.push_back(make_item(sli_pkg::ACT_LIST, 32'hffff_ffff));
      pending_items.push_back(make_item(sli_pkg::ACT_DELETE, 32'd7));
      pending_items.push_back(make_item(sli_pkg::ACT_DELETE, 32'd0));
      for (int i = 0; i < 13; i++)
         pending_items.push_back(make_item(sli_pkg::ACT_INSERT, 32'(i * 3 - 20)));
      pending_items.push_back(make_item(sli_pkg::ACT_INSERT, 32'd1));
      pending_items.push_back(make_item(sli_pkg::ACT_LIST, 32'd0));
      pending_items.push_back(make_item(sli_pkg::ACT_NONE, 32'd0));

      // Pause the sender until every expected result has arrived
      wait (pending_items.size() == 0);
      hold_off = 1'b1;
      @(negedge clock);
      while (req_tvalid) @(negedge clock);
      wait (expected_results.size() == 0);
      @(posedge clock);
      hold_off = 1'b0;

      // Random mix, with a calm stretch in the middle
      for (int i = 0; i < 75; i++) begin
         logic [31:0] v;
         int r;
         v = pick_value();
         r = $urandom_range(0, 99);
         if (r < 40) pending_items.push_back(make_item(sli_pkg::ACT_INSERT, v));
         else if (r < 80) pending_items.push_back(make_item(sli_pkg::ACT_DELETE, v));
         else if (r < 95) pending_items.push_back(make_item(sli_pkg::ACT_LIST, v));
         else pending_items.push_back(make_item(sli_pkg::ACT_NONE, v));
      end
      wait (pending_items.size() < 60);
      calm = 1'b1;
      wait (pending_items.size() < 30);
      calm = 1'b0;
      wait (pending_items.size() == 0);
      @(negedge clock);
      while (req_tvalid) @(negedge clock);
      wait (expected_results.size() == 0);
      repeat (50) @(posedge clock);

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// File: sim.f
sv/sli_pkg.sv
sv/sli_ram.sv
sv/sli_ctrl.sv
sv/sorted_list_insert_delete.sv
tb/sorted_list_insert_delete_tb.sv
